// ----- rtl/neighbor_mean_outlier_filter_defines.svh -----
// Assertion macros shared by the neighbor mean outlier filter RTL.
// Needs nothing else; simulation builds leave SYNTH undefined to keep the checks.
`ifndef NEIGHBOR_MEAN_OUTLIER_FILTER_DEFINES_SVH
`define NEIGHBOR_MEAN_OUTLIER_FILTER_DEFINES_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define NMOF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Trigger in one cycle, consequence in the next.
`define NMOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NMOF_ASSERT(lbl, clk, rst_n, prop, msg)
`define NMOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/nmof_pkg.sv -----
// Package of the neighbor mean outlier filter: register indexes, fixed field widths,
// reset values and the per-cell flag struct. Depends on nothing.
package nmof_pkg;

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 20;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd2;

	// Register fields
	localparam int DIM_BITS  = 11;
	localparam int THR_BITS  = 20;
	localparam int DIM_MIN   = 3;
	localparam int DIM_RESET = 1024;
	localparam logic [THR_BITS-1:0] THR_RESET = 20'd1010;

	// Mean of eight neighbors: add half of eight, divide by eight toward zero.
	localparam int MEAN_SHIFT = 3;
	localparam int ROUND_HALF = 4;
	localparam int ROUND_BIAS = 7;

	// What the output stage must do with one cell.
	typedef struct packed {
		logic keep;      // the request yields a result
		logic interior;  // the cell is away from all four borders
		logic last;      // the result closes the frame
	} cell_flags_t;

endpackage

// ----- rtl/neighbor_mean_outlier_filter.sv -----
// Path: a request passes the stage 1, window, partial sum, full sum, mean and output registers.
// Throughput: one request per clock; input stalls only while the output register is full.
// The line memory is read and written once per request, which fixes that rate at one.
// Reset (arst_n low): counters clear, registers return to 1024 x 1024 and threshold 1010.
// The line memory is never cleared; no stale contents can reach an output.
`include "neighbor_mean_outlier_filter_defines.svh"

// Cleans an elevation grid streamed in raster order. Every interior cell is compared with
// the rounded mean of its eight raw neighbors and replaced by that mean when the absolute
// difference reaches the threshold. Border cells pass unchanged.
//
// Structure: one synchronous memory holds the two previous raw rows, packed side by side
// in one word per column. A request reads its column in the cycle it is accepted and writes
// back {row above, new sample} from stage 1, so the memory acts as two chained line
// buffers. The same write step shifts a 3x3 window of registers. Four further pipeline
// stages add the neighbors, round the mean, and compare and select.
//
// The window never sees a replaced value, since only raw samples enter the memory.
// Results trail the input by one row plus one cell; num_cols + 1 pad requests after the
// frame flush the last row out. The final cell of the frame carries tlast.
module neighbor_mean_outlier_filter #(
	parameter int MAX_COLS    = 1024,
	parameter int MAX_ROWS    = 1024,
	parameter int SAMPLE_BITS = 20,
	localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [DATA_BITS-1:0]                 s_tdata,   // [SAMPLE_BITS-1:0] elevation_tenths
	input  logic [0:0]                           s_tuser,   // [0] pad
	// Output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [DATA_BITS-1:0]                 m_tdata,   // [SAMPLE_BITS-1:0] cleaned_tenths
	output logic                                 m_tlast,   // frame_end
	// Configuration writes
	input  logic                                 cfg_we,
	input  logic [nmof_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [nmof_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int SB        = SAMPLE_BITS;
	localparam int COL_BITS  = $clog2(MAX_COLS);
	localparam int NC_BITS   = $clog2(MAX_COLS + 1);
	localparam int ROW_BITS  = $clog2(MAX_ROWS + 2);
	localparam int SUM4_BITS = SB + 2;
	localparam int SUM_BITS  = SB + 4;
	localparam int DIFF_BITS = SB + 1;
	localparam int CMP_BITS  = (DIFF_BITS > nmof_pkg::THR_BITS) ? DIFF_BITS : nmof_pkg::THR_BITS;
	localparam int COLS_RST  = (nmof_pkg::DIM_RESET > MAX_COLS) ? MAX_COLS : nmof_pkg::DIM_RESET;
	localparam int ROWS_RST  = (nmof_pkg::DIM_RESET > MAX_ROWS) ? MAX_ROWS : nmof_pkg::DIM_RESET;

	// ------------------------------------------------------------------
	// Handshake. The whole pipeline moves together whenever the output
	// register is free or is being emptied in this cycle.
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic en;
	logic accept;

	assign en       = !out_valid_q || m_tready;
	assign accept   = s_tvalid && en;
	assign s_tready = en;

	// ------------------------------------------------------------------
	// Configuration. Dimensions are clamped to the supported range on write.
	// ------------------------------------------------------------------
	logic [NC_BITS-1:0]                ncols_q;
	logic [ROW_BITS-1:0]               nrows_q;
	logic [nmof_pkg::THR_BITS-1:0]     thr_q;
	logic [nmof_pkg::DIM_BITS-1:0]     cfg_dim;
	logic [NC_BITS-1:0]                cols_clamped;
	logic [ROW_BITS-1:0]               rows_clamped;
	logic                              dim_write;

	assign cfg_dim   = cfg_data[nmof_pkg::DIM_BITS-1:0];
	assign dim_write = cfg_we && (cfg_index == nmof_pkg::REG_NUM_COLS ||
		cfg_index == nmof_pkg::REG_NUM_ROWS);

	always_comb begin
		if (32'(cfg_dim) < 32'(nmof_pkg::DIM_MIN)) begin
			cols_clamped = NC_BITS'(nmof_pkg::DIM_MIN);
			rows_clamped = ROW_BITS'(nmof_pkg::DIM_MIN);
		end else begin
			cols_clamped = (32'(cfg_dim) > 32'(MAX_COLS)) ? NC_BITS'(MAX_COLS) : NC_BITS'(cfg_dim);
			rows_clamped = (32'(cfg_dim) > 32'(MAX_ROWS)) ? ROW_BITS'(MAX_ROWS) : ROW_BITS'(cfg_dim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncols_q <= NC_BITS'(COLS_RST);
			nrows_q <= ROW_BITS'(ROWS_RST);
			thr_q   <= nmof_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nmof_pkg::REG_NUM_COLS:  ncols_q <= cols_clamped;
				nmof_pkg::REG_NUM_ROWS:  nrows_q <= rows_clamped;
				nmof_pkg::REG_THRESHOLD: thr_q   <= cfg_data[nmof_pkg::THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Position of the incoming request and the cell it completes. That
	// cell sits one row and one column back, or at the end of the row before last
	// when the request opens a row.
	// ------------------------------------------------------------------
	logic [COL_BITS-1:0]       col_count_q;
	logic [ROW_BITS-1:0]       row_count_q;
	logic                      col_zero, col_ge2, col_last;
	logic                      row_ge1, row_ge2, row_le_n, row_le_nm1, row_is_np1;
	nmof_pkg::cell_flags_t     flags_in;
	logic signed [SB-1:0]      sample_in;

	assign col_zero   = (col_count_q == '0);
	assign col_ge2    = (col_count_q >= COL_BITS'(2));
	assign col_last   = (NC_BITS'(col_count_q) == ncols_q - 1'b1);
	assign row_ge1    = (row_count_q != '0);
	assign row_ge2    = (row_count_q >= ROW_BITS'(2));
	assign row_le_n   = (row_count_q <= nrows_q);
	assign row_le_nm1 = (row_count_q <= nrows_q - 1'b1);
	assign row_is_np1 = (row_count_q == nrows_q + 1'b1);

	always_comb begin
		flags_in.keep     = col_zero ? row_ge2 : (row_ge1 && row_le_n);
		flags_in.interior = col_ge2 && row_ge2 && row_le_nm1;
		flags_in.last     = col_zero && row_is_np1;
	end

	// A pad request enters the line buffers as zero.
	assign sample_in = s_tuser[0] ? '0 : $signed(s_tdata[SB-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (dim_write) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (accept) begin
			if (flags_in.last) begin
				col_count_q <= '0;
				row_count_q <= '0;
			end else if (col_last) begin
				col_count_q <= '0;
				row_count_q <= row_count_q + 1'b1;
			end else begin
				col_count_q <= col_count_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: memory read data arrives; write-back takes place here.
	// ------------------------------------------------------------------
	logic                      valid_s1;
	logic signed [SB-1:0]      x_s1;
	logic [COL_BITS-1:0]       c_s1;
	nmof_pkg::cell_flags_t     fl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= sample_in;
			c_s1  <= col_count_q;
			fl_s1 <= flags_in;
		end
	end

	// Line memory: upper half is two rows back, lower half one row back.
	// Read at accept, write from stage 1 at the same column. A new frame
	// may read the column that the closing request is writing, so the write
	// data is forwarded in that case.
	logic [2*SB-1:0]           line_mem [MAX_COLS];
	logic [2*SB-1:0]           rd_q;
	logic [2*SB-1:0]           wr_word;
	logic                      wr_en;

	assign wr_en   = en && valid_s1;
	assign wr_word = {rd_q[SB-1:0], x_s1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[c_s1] <= wr_word;
		end
		if (accept) begin
			rd_q <= (wr_en && c_s1 == col_count_q) ? wr_word : line_mem[col_count_q];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the 3x3 window. Columns move left; the right column takes
	// the two stored rows and the new sample.
	// ------------------------------------------------------------------
	logic signed [SB-1:0]      win_q [9];
	logic                      valid_s2;
	nmof_pkg::cell_flags_t     fl_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= $signed(rd_q[2*SB-1:SB]);
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= $signed(rd_q[SB-1:0]);
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= x_s1;
			fl_s2    <= fl_s1;
		end
	end

	// Requests that complete no cell are dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && fl_s1.keep;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: two partial sums of four neighbors each.
	// ------------------------------------------------------------------
	logic                         valid_s3;
	logic signed [SUM4_BITS-1:0]  sa_s3, sb_s3;
	logic signed [SB-1:0]         center_s3;
	nmof_pkg::cell_flags_t        fl_s3;

	// Stage 4: full sum plus half of the divisor.
	logic                         valid_s4;
	logic signed [SUM_BITS-1:0]   t_s4;
	logic signed [SB-1:0]         center_s4;
	nmof_pkg::cell_flags_t        fl_s4;

	// Stage 5: mean, divided by eight with truncation toward zero.
	logic                         valid_s5;
	logic signed [SB-1:0]         mean_s5;
	logic signed [SB-1:0]         center_s5;
	nmof_pkg::cell_flags_t        fl_s5;

	logic signed [SUM_BITS-1:0]   t_adj;

	// A negative sum needs the divisor minus one added before the arithmetic
	// shift, so that the quotient rounds toward zero.
	assign t_adj = t_s4[SUM_BITS-1] ? t_s4 + SUM_BITS'(nmof_pkg::ROUND_BIAS) : t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s3     <= SUM4_BITS'(win_q[0]) + SUM4_BITS'(win_q[1]) +
				SUM4_BITS'(win_q[2]) + SUM4_BITS'(win_q[3]);
			sb_s3     <= SUM4_BITS'(win_q[5]) + SUM4_BITS'(win_q[6]) +
				SUM4_BITS'(win_q[7]) + SUM4_BITS'(win_q[8]);
			center_s3 <= win_q[4];
			fl_s3     <= fl_s2;

			t_s4      <= SUM_BITS'(sa_s3) + SUM_BITS'(sb_s3) + SUM_BITS'(nmof_pkg::ROUND_HALF);
			center_s4 <= center_s3;
			fl_s4     <= fl_s3;

			mean_s5   <= SB'(t_adj >>> nmof_pkg::MEAN_SHIFT);
			center_s5 <= center_s4;
			fl_s5     <= fl_s4;
		end
	end

	// ------------------------------------------------------------------
	// Output register: absolute difference, threshold compare, selection.
	// ------------------------------------------------------------------
	logic signed [DIFF_BITS-1:0]  diff;
	logic [DIFF_BITS-1:0]         abs_diff;
	logic                         replace;
	logic [SB-1:0]                cleaned_q;
	logic                         last_q;

	assign diff     = DIFF_BITS'(center_s5) - DIFF_BITS'(mean_s5);
	assign abs_diff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
	assign replace  = fl_s5.interior && (CMP_BITS'(abs_diff) >= CMP_BITS'(thr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cleaned_q <= replace ? mean_s5 : center_s5;
			last_q    <= fl_s5.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_BITS'(cleaned_q);
	assign m_tlast  = last_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`NMOF_ASSERT(a_col_in_range, clk, arst_n, (NC_BITS'(col_count_q) < ncols_q), "column count beyond row length")
	`NMOF_ASSERT(a_row_in_range, clk, arst_n, (row_count_q <= nrows_q + 1'b1), "row count beyond flush row")
	`NMOF_ASSERT_NEXT(a_end_restarts, clk, arst_n, accept && flags_in.last, col_count_q == '0 && row_count_q == '0, "frame end did not restart the position")
	`NMOF_ASSERT(a_last_on_border, clk, arst_n, (valid_s5 && fl_s5.last) |-> !fl_s5.interior, "frame end marked on an interior cell")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the neighbor mean outlier filter: a scoreboard class that predicts
// every cleaned cell, plus tasks that stream elevation frames and write the configuration port.
// Depends on nmof_pkg and the neighbor_mean_outlier_filter RTL only.
module testbench;

	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int SAMPLE_BITS = 20;
	localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PAD_BITS    = DATA_BITS - SAMPLE_BITS;
	localparam int SAMPLE_MIN  = -(1 << (SAMPLE_BITS - 1));
	localparam int SAMPLE_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;

	// Register index that the block does not decode; writes to it must be ignored.
	localparam logic [nmof_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	// This many idle cycles leave the pipeline empty for sure.
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 100000;
	localparam int RANDOM_ITEMS  = 1300;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] cleaned;
		logic                   frame_end;
	} cleaned_cell_t;

	// Receiver behaviors, one picked at random whenever the current one runs out.
	typedef enum int {
		ALWAYS_READY,
		COIN_READY,
		PERIODIC_STALL,
		RARE_READY
	} ready_style_e;

	// Keeps a private copy of the filter state, works out the cleaned cell that each accepted
	// request releases, and matches the cells that leave the block against those, in order.
	class cleaned_cell_board;
		int cols;
		int rows;
		int thr;
		int line_rows[2*MAX_COLS];
		int win[9];
		int col_pos;
		int row_pos;
		int failures;
		cleaned_cell_t expected_cells[$];

		function new();
			cols = nmof_pkg::DIM_RESET;
			rows = nmof_pkg::DIM_RESET;
			thr = int'(nmof_pkg::THR_RESET);
			foreach (line_rows[i]) line_rows[i] = 0;
			foreach (win[i]) win[i] = 0;
			col_pos = 0;
			row_pos = 0;
			failures = 0;
		endfunction

		function int clamp_dim(logic [nmof_pkg::CFG_DATA_BITS-1:0] value, int hi);
			int d;
			d = int'(value[nmof_pkg::DIM_BITS-1:0]);
			if (d < nmof_pkg::DIM_MIN) return nmof_pkg::DIM_MIN;
			if (d > hi) return hi;
			return d;
		endfunction

		function void write_register(logic [nmof_pkg::CFG_IDX_BITS-1:0] idx,
				logic [nmof_pkg::CFG_DATA_BITS-1:0] value);
			case (idx)
				nmof_pkg::REG_NUM_COLS: begin
					cols = clamp_dim(value, MAX_COLS);
					col_pos = 0;
					row_pos = 0;
				end
				nmof_pkg::REG_NUM_ROWS: begin
					rows = clamp_dim(value, MAX_ROWS);
					col_pos = 0;
					row_pos = 0;
				end
				nmof_pkg::REG_THRESHOLD: thr = int'(value[nmof_pkg::THR_BITS-1:0]);
				default: ;
			endcase
		endfunction

		function void note_request(logic [SAMPLE_BITS-1:0] raw, logic pad);
			int x, c, older, prev, cr, cc, sum, mean, diff, result, k;
			cleaned_cell_t exp_cell;
			x = pad ? 0 : int'($signed(raw));
			c = (col_pos >= cols) ? cols - 1 : col_pos;

			// Two chained line buffers: the upper bank is two rows back, the lower one row back.
			older = line_rows[MAX_COLS + c];
			prev = line_rows[c];
			line_rows[MAX_COLS + c] = prev;
			line_rows[c] = x;

			for (k = 0; k < 3; k++) begin
				win[k*3 + 0] = win[k*3 + 1];
				win[k*3 + 1] = win[k*3 + 2];
			end
			win[2] = older;
			win[5] = prev;
			win[8] = x;

			// The window center is one row and one column back, or ends the row before last.
			if (c >= 1) begin
				cr = row_pos - 1;
				cc = c - 1;
			end else begin
				cr = row_pos - 2;
				cc = cols - 1;
			end

			if (c + 1 >= cols) begin
				col_pos = 0;
				row_pos++;
			end else begin
				col_pos = c + 1;
			end

			if (cr < 0 || cr >= rows) return;

			result = win[4];
			if (cr >= 1 && cr <= rows - 2 && cc >= 1 && cc <= cols - 2) begin
				sum = 0;
				for (k = 0; k < 9; k++)
					if (k != 4) sum += win[k];
				// Integer division truncates toward zero, which is the rounding wanted here.
				mean = (sum + 4) / 8;
				diff = win[4] - mean;
				if (diff < 0) diff = -diff;
				if (diff >= thr) result = mean;
			end

			exp_cell.cleaned = result[SAMPLE_BITS-1:0];
			exp_cell.frame_end = (cr == rows - 1) && (cc == cols - 1);
			expected_cells.push_back(exp_cell);
			if (exp_cell.frame_end) begin
				col_pos = 0;
				row_pos = 0;
			end
		endfunction

		function void check_cell(logic [DATA_BITS-1:0] data, logic last);
			cleaned_cell_t want;
			logic [DATA_BITS-1:0] want_word;
			if (expected_cells.size() == 0) begin
				failures++;
				$display("%0t: cell with nothing expected, actual data %0d last %0b",
					$time, $signed(data[SAMPLE_BITS-1:0]), last);
				return;
			end
			want = expected_cells.pop_front();
			want_word = {{PAD_BITS{1'b0}}, want.cleaned};
			if (data !== want_word) begin
				failures++;
				$display("%0t: cleaned_tenths mismatch, expected %0d (0x%h), actual %0d (0x%h)",
					$time, $signed(want.cleaned), want_word,
					$signed(data[SAMPLE_BITS-1:0]), data);
			end
			if (last !== want.frame_end) begin
				failures++;
				$display("%0t: frame_end mismatch, expected %0b, actual %0b",
					$time, want.frame_end, last);
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [DATA_BITS-1:0]               s_tdata = '0;   // [SAMPLE_BITS-1:0] elevation_tenths
	logic [0:0]                         s_tuser = '0;   // [0] pad
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [DATA_BITS-1:0]               m_tdata;        // [SAMPLE_BITS-1:0] cleaned_tenths
	logic                               m_tlast;        // frame_end
	logic                               cfg_we = 1'b0;
	logic [nmof_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [nmof_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	cleaned_cell_board board;

	// Sender pacing: requests go out in bursts, separated by short random gaps.
	int burst_left = 0;
	int requests_sent = 0;

	// Receiver pacing state.
	ready_style_e ready_style = ALWAYS_READY;
	int ready_left = 0;
	int ready_tick = 0;

	neighbor_mean_outlier_filter #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run, even with every stall at its longest.
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// The receiver changes its stall pattern at random points. Ready moves on the
	// falling edge so the block sees a settled value at every rising edge.
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_style = ready_style_e'($urandom_range(0, 3));
			ready_left = $urandom_range(50, 400);
		end
		ready_left--;
		ready_tick++;
		case (ready_style)
			ALWAYS_READY:   m_tready <= 1'b1;
			COIN_READY:     m_tready <= 1'($urandom_range(0, 1));
			PERIODIC_STALL: m_tready <= (ready_tick % 4 != 0);
			RARE_READY:     m_tready <= ($urandom_range(0, 5) == 0);
			default:        m_tready <= 1'b1;
		endcase
	end

	// Every cell that leaves the block is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_cell(m_tdata, m_tlast);
	end

	// Offers one request and returns once the block has taken it. Valid stays high into the
	// next call, so back-to-back requests go out one per clock inside a burst when not stalled.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic pad);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			// Now and then a long burst gives a stretch without any sender idling.
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_BITS{1'b0}}, value};
		s_tuser <= pad;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(value, pad);
		burst_left--;
		requests_sent++;
	endtask

	// Holds the sender off until every predicted cell has come out, then lets the pipeline
	// settle for the given number of cycles. Bounded so a hung block still reaches the end.
	task automatic drain(input int settle);
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.expected_cells.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (settle) @(posedge clk);
	endtask

	// One register write; callers drain the block first so the write lands while it is idle.
	task automatic write_reg(input logic [nmof_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [nmof_pkg::CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.write_register(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Small grid sizes keep frames short. The bits above the 11-bit field are random, since
	// the block must mask them, and a few picks fall below the minimum to exercise the clamp.
	function automatic logic [nmof_pkg::CFG_DATA_BITS-1:0] pick_dim();
		logic [nmof_pkg::CFG_DATA_BITS-1:0] word;
		word = nmof_pkg::CFG_DATA_BITS'($urandom);
		word[nmof_pkg::DIM_BITS-1:0] = ($urandom_range(0, 9) == 0) ?
			nmof_pkg::DIM_BITS'($urandom_range(0, 2)) :
			nmof_pkg::DIM_BITS'($urandom_range(3, 12));
		return word;
	endfunction

	// Streams cell_count cells of synthetic terrain for the current grid size: a sloped surface
	// with small noise and occasional spikes, or now and then full-range random content. A few
	// pads land inside the frame. With flushing, the frame is followed by the flush requests,
	// usually exactly num_cols + 1 of them, some not marked as pads, and sometimes a wrong count.
	task automatic send_frame(input int cell_count, input bit with_flush);
		int base, drift_r, drift_c, v, i, pause_at, flush_n;
		bit wild;
		wild = ($urandom_range(0, 5) == 0);
		base = int'($urandom_range(0, 800000)) - 400000;
		drift_r = int'($urandom_range(0, 400)) - 200;
		drift_c = int'($urandom_range(0, 400)) - 200;
		pause_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, cell_count - 1)) : -1;
		flush_n = ($urandom_range(0, 9) == 0) ?
			int'($urandom_range(0, board.cols + 3)) : board.cols + 1;
		for (i = 0; i < cell_count; i++) begin
			// Occasionally the sender waits mid-frame until all predicted cells are out.
			if (i == pause_at) drain(0);
			if (wild) begin
				v = int'($signed(SAMPLE_BITS'($urandom)));
			end else begin
				v = base + drift_r * (i / board.cols) + drift_c * (i % board.cols)
					+ int'($urandom_range(0, 100)) - 50;
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1)) v += int'($urandom_range(500, 300000));
					else v -= int'($urandom_range(500, 300000));
				end
				if (v < SAMPLE_MIN) v = SAMPLE_MIN;
				if (v > SAMPLE_MAX) v = SAMPLE_MAX;
			end
			send_sample(v[SAMPLE_BITS-1:0], $urandom_range(0, 49) == 0);
		end
		if (with_flush) begin
			for (i = 0; i < flush_n; i++)
				send_sample(SAMPLE_BITS'($urandom), $urandom_range(0, 7) != 0);
		end
	endtask

	initial begin
		int i;
		logic [nmof_pkg::CFG_DATA_BITS-1:0] thr_word;
		board = new();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed frame one: a 3x3 grid, both sizes written below the minimum so they clamp
		// to 3, with the threshold at its maximum. The center is the most negative sample and
		// all neighbors the most positive, so the difference equals the threshold exactly and
		// the center must be replaced. The flush ends with a request that is not a pad.
		write_reg(nmof_pkg::REG_NUM_COLS, 20'h00001);
		write_reg(nmof_pkg::REG_NUM_ROWS, 20'hFF802);
		write_reg(nmof_pkg::REG_THRESHOLD, 20'hFFFFF);
		write_reg(REG_UNUSED, 20'h00005);
		for (i = 0; i < 9; i++)
			send_sample((i == 4) ? 20'h80000 : 20'h7FFFF, 1'b0);
		for (i = 0; i < 3; i++)
			send_sample(20'h12345, 1'b1);
		send_sample(20'h80000, 1'b0);

		// Directed frame two: zero threshold, so the interior cell always takes the mean. The
		// center is the most positive sample and the neighbors the most negative, except one
		// pad inside the frame whose data must be read as zero.
		drain(SETTLE_CYCLES);
		write_reg(nmof_pkg::REG_THRESHOLD, 20'h00000);
		for (i = 0; i < 9; i++) begin
			if (i == 4) send_sample(20'h7FFFF, 1'b0);
			else if (i == 7) send_sample(20'hFFFFF, 1'b1);
			else send_sample(20'h80000, 1'b0);
		end
		for (i = 0; i < 4; i++)
			send_sample(20'h00000, 1'b1);

		// Random part: mostly well-formed frames of random size, content and threshold.
		// Some frames are cut short and followed by a register write, which either restarts
		// the frame (a size) or lets it carry on (the threshold).
		while (requests_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				drain(SETTLE_CYCLES);
				write_reg(nmof_pkg::REG_NUM_COLS, pick_dim());
				write_reg(nmof_pkg::REG_NUM_ROWS, pick_dim());
				case ($urandom_range(0, 4))
					0: thr_word = 20'h00000;
					1: thr_word = nmof_pkg::THR_RESET;
					2: thr_word = 20'hFFFFF;
					3: thr_word = nmof_pkg::CFG_DATA_BITS'($urandom_range(0, 3000));
					default: thr_word = nmof_pkg::CFG_DATA_BITS'($urandom);
				endcase
				write_reg(nmof_pkg::REG_THRESHOLD, thr_word);
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_UNUSED, nmof_pkg::CFG_DATA_BITS'($urandom));
			end
			if ($urandom_range(0, 7) == 0) begin
				send_frame($urandom_range(1, board.cols * board.rows - 1), 1'b0);
				drain(SETTLE_CYCLES);
				if ($urandom_range(0, 1))
					write_reg(nmof_pkg::REG_NUM_COLS, pick_dim());
				else
					write_reg(nmof_pkg::REG_THRESHOLD,
						nmof_pkg::CFG_DATA_BITS'($urandom_range(0, 3000)));
			end else begin
				send_frame(board.cols * board.rows, 1'b1);
			end
		end

		// Let everything drain; any cell that shows up late is flagged by the checker.
		drain(SETTLE_CYCLES);
		if (board.expected_cells.size() != 0) begin
			board.failures++;
			$display("%0t: %0d expected cells never arrived", $time,
				board.expected_cells.size());
		end
		if (board.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
